### hdl/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types and constants of the stack machine interpreter core.
// ----------------------------------------------------------------------------
package smi_pkg;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_PALL  = 4'd1,
        OP_PINT  = 4'd2,
        OP_POP   = 4'd3,
        OP_SWAP  = 4'd4,
        OP_ADD   = 4'd5,
        OP_SUB   = 4'd6,
        OP_DIV   = 4'd7,
        OP_MUL   = 4'd8,
        OP_MOD   = 4'd9,
        OP_PCHAR = 4'd10,
        OP_PSTR  = 4'd11,
        OP_ROTL  = 4'd12,
        OP_ROTR  = 4'd13,
        OP_NOP   = 4'd14
    } op_t;

    typedef enum logic [2:0] {
        KIND_INT    = 3'd0,
        KIND_CHAR   = 3'd1,
        KIND_STRCH  = 3'd2,
        KIND_STREND = 3'd3,
        KIND_ERR    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_SHORT  = 3'd2,
        ST_DIVZ   = 3'd3,
        ST_CHAR   = 3'd4,
        ST_FULL   = 3'd5,
        ST_HALTED = 3'd6
    } status_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
        status_t            status;
        logic               last;
    } res_t;

    typedef struct packed {
        logic halted;
        logic busy;
    } stat_t;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [2:0] REG_PUSH_AT_BOTTOM = 3'd0;

endpackage

### hdl/smi_front.sv
// ----------------------------------------------------------------------------
// smi_front
// Command intake: decodes the mode field and queues commands for the back end.
// ----------------------------------------------------------------------------
module smi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          mode,
    input  logic signed [31:0]  push_value,
    input  logic                push,
    output logic                full,
    input  logic                cmd_pop,
    output smi_pkg::cmd_t       cmd,
    output logic                cmd_empty
);
    import smi_pkg::*;

    cmd_t                   q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wptr_reg;
    logic [QUEUE_AW-1:0]    rptr_reg;
    logic [QUEUE_AW:0]      cnt_reg;
    cmd_t                   dec;
    logic                   wr_en;
    logic                   rd_en;

    always_comb
    begin
        dec.op    = (mode > 4'(OP_NOP)) ? OP_NOP : op_t'(mode);
        dec.value = push_value;
    end

    assign full      = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign cmd_empty = (cnt_reg == '0);
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && !cmd_empty;
    assign cmd       = q_mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/smi_alu.sv
// ----------------------------------------------------------------------------
// smi_alu
// Iterative multiply, divide and modulo unit, one bit per cycle.
// ----------------------------------------------------------------------------
module smi_alu #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  smi_pkg::op_t        op,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic                done,
    output logic signed [W-1:0] result
);
    import smi_pkg::*;

    localparam int CNTW = $clog2(W + 1);

    typedef enum logic [1:0] {A_IDLE, A_RUN, A_DONE} astate_t;

    astate_t        state_reg;
    op_t            op_reg;
    logic [W-1:0]   x_reg;
    logic [W-1:0]   y_reg;
    logic [W:0]     acc_reg;
    logic           na_reg;
    logic           nb_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W:0]     sh;
    logic [W-1:0]   q_neg;
    logic [W-1:0]   r_neg;

    assign sh    = {acc_reg[W-1:0], x_reg[W-1]};
    assign q_neg = W'(0) - x_reg;
    assign r_neg = W'(0) - acc_reg[W-1:0];
    assign done  = (state_reg == A_DONE);

    always_comb
    begin
        case (op_reg)
            OP_MUL:  result = acc_reg[W-1:0];
            OP_DIV:  result = (na_reg != nb_reg) ? q_neg : x_reg;
            default: result = na_reg ? r_neg : acc_reg[W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= A_RUN;
                        cnt_reg   <= '0;
                    end
                end
                A_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(W - 1))
                    begin
                        state_reg <= A_DONE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == A_IDLE && start)
        begin
            op_reg  <= op;
            acc_reg <= '0;
            na_reg  <= a[W-1];
            nb_reg  <= b[W-1];
            if (op == OP_MUL)
            begin
                x_reg <= a;
                y_reg <= b;
            end
            else
            begin
                x_reg <= a[W-1] ? W'(0) - a : a;
                y_reg <= b[W-1] ? W'(0) - b : b;
            end
        end
        else if (state_reg == A_RUN)
        begin
            if (op_reg == OP_MUL)
            begin
                if (x_reg[0])
                begin
                    acc_reg <= {1'b0, acc_reg[W-1:0] + y_reg};
                end
                x_reg <= x_reg >> 1;
                y_reg <= y_reg << 1;
            end
            else if (sh >= {1'b0, y_reg})
            begin
                acc_reg <= sh - {1'b0, y_reg};
                x_reg   <= {x_reg[W-2:0], 1'b1};
            end
            else
            begin
                acc_reg <= sh;
                x_reg   <= {x_reg[W-2:0], 1'b0};
            end
        end
    end

endmodule

### hdl/smi_outq.sv
// ----------------------------------------------------------------------------
// smi_outq
// Result queue between the execution back end and the result ports.
// ----------------------------------------------------------------------------
module smi_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_push,
    input  smi_pkg::res_t   res_in,
    output logic            res_full,
    input  logic            pop,
    output logic            empty,
    output smi_pkg::res_t   res_out
);
    import smi_pkg::*;

    res_t                   q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wptr_reg;
    logic [QUEUE_AW-1:0]    rptr_reg;
    logic [QUEUE_AW:0]      cnt_reg;
    logic                   wr_en;
    logic                   rd_en;

    assign res_full = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;
    assign res_out  = q_mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/smi_back.sv
// ----------------------------------------------------------------------------
// smi_back
// Execution sequencer: circular stack memory, command steps and result beats.
// ----------------------------------------------------------------------------
module smi_back #(
    parameter int DEPTH = 32,
    parameter int W     = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_at_bottom,
    input  smi_pkg::cmd_t   cmd,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    output smi_pkg::res_t   res,
    output logic            res_push,
    input  logic            res_full,
    output smi_pkg::stat_t  stat
);
    import smi_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic signed [W-1:0] CHAR_MAX = W'(127);

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_SWAP, S_ALU, S_WALK_RD, S_WALK_CHK, S_STREND, S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [IW-1:0]      top_reg, top_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               halted_reg, halted_next;
    op_t                op_reg, op_next;
    logic signed [W-1:0] b_reg, b_next;
    logic [CW-1:0]      idx_reg, idx_next;
    res_t               res_reg, res_next;

    logic signed [W-1:0] mem [DEPTH];
    logic signed [W-1:0] rd_data;
    logic [IW-1:0]      raddr;
    logic [IW-1:0]      waddr;
    logic signed [W-1:0] wdata;
    logic               mem_we;

    logic               alu_start;
    logic               alu_done;
    logic signed [W-1:0] alu_result;

    logic               do_fail;
    status_t            fail_status;
    logic [IW-1:0]      slot1;
    logic [IW-1:0]      slotc;
    logic [IW-1:0]      slotlast;
    logic [IW-1:0]      topm1;
    logic signed [W-1:0] pushv;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] t, input logic [CW-1:0] i);
        logic [IW:0] s;
        s = {1'b0, t} + (IW+1)'(i);
        if (s >= (IW+1)'(DEPTH))
        begin
            s = s - (IW+1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic is_strch(input logic signed [W-1:0] v);
        return !v[W-1] && (v != '0) && (v <= CHAR_MAX);
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic signed [W-1:0] v,
                                    input logic l);
        res_t r;
        r.kind   = k;
        r.value  = 32'(v);
        r.status = ST_OK;
        r.last   = l;
        return r;
    endfunction

    smi_alu #(.W(W)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (op_reg),
        .a      (rd_data),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign slot1    = slot_of(top_reg, CW'(1));
    assign slotc    = slot_of(top_reg, count_reg);
    assign slotlast = slot_of(top_reg, count_reg - 1'b1);
    assign topm1    = (top_reg == '0) ? IW'(DEPTH - 1) : top_reg - 1'b1;
    assign pushv    = W'(cmd.value);
    assign res      = res_reg;
    assign stat.halted = halted_reg;
    assign stat.busy   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        top_next    = top_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        op_next     = op_reg;
        b_next      = b_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        raddr       = top_reg;
        waddr       = top_reg;
        wdata       = b_reg;
        mem_we      = 1'b0;
        cmd_pop     = 1'b0;
        alu_start   = 1'b0;
        res_push    = 1'b0;
        do_fail     = 1'b0;
        fail_status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    op_next  = cmd.op;
                    idx_next = '0;
                    if (halted_reg)
                    begin
                        do_fail     = 1'b1;
                        fail_status = ST_HALTED;
                    end
                    else
                    begin
                        case (cmd.op)
                            OP_PUSH:
                            begin
                                if (count_reg == CW'(DEPTH))
                                begin
                                    do_fail     = 1'b1;
                                    fail_status = ST_FULL;
                                end
                                else
                                begin
                                    mem_we     = 1'b1;
                                    wdata      = pushv;
                                    count_next = count_reg + 1'b1;
                                    if (push_at_bottom)
                                    begin
                                        waddr = slotc;
                                    end
                                    else
                                    begin
                                        waddr    = topm1;
                                        top_next = topm1;
                                    end
                                end
                            end
                            OP_PALL:
                            begin
                                if (count_reg != '0)
                                begin
                                    state_next = S_WALK_RD;
                                end
                            end
                            OP_PSTR:
                            begin
                                state_next = (count_reg == '0) ? S_STREND : S_WALK_RD;
                            end
                            OP_PINT, OP_PCHAR:
                            begin
                                if (count_reg == '0)
                                begin
                                    do_fail     = 1'b1;
                                    fail_status = ST_EMPTY;
                                end
                                else
                                begin
                                    state_next = S_RD1;
                                end
                            end
                            OP_POP:
                            begin
                                if (count_reg == '0)
                                begin
                                    do_fail     = 1'b1;
                                    fail_status = ST_EMPTY;
                                end
                                else
                                begin
                                    top_next   = slot1;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    do_fail     = 1'b1;
                                    fail_status = ST_SHORT;
                                end
                                else
                                begin
                                    state_next = S_RD1;
                                end
                            end
                            OP_ROTL:
                            begin
                                if (count_reg >= CW'(2))
                                begin
                                    state_next = S_RD1;
                                end
                            end
                            OP_ROTR:
                            begin
                                if (count_reg >= CW'(2))
                                begin
                                    raddr      = slotlast;
                                    state_next = S_RD1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_RD1:
            begin
                b_next = rd_data;
                case (op_reg)
                    OP_PINT:
                    begin
                        res_next   = mk_res(KIND_INT, rd_data, 1'b1);
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                    OP_PCHAR:
                    begin
                        if (rd_data[W-1] || rd_data > CHAR_MAX)
                        begin
                            do_fail     = 1'b1;
                            fail_status = ST_CHAR;
                        end
                        else
                        begin
                            res_next   = mk_res(KIND_CHAR, rd_data, 1'b1);
                            ret_next   = S_IDLE;
                            state_next = S_EMIT;
                        end
                    end
                    OP_ROTL:
                    begin
                        mem_we     = 1'b1;
                        waddr      = slotc;
                        wdata      = rd_data;
                        top_next   = slot1;
                        state_next = S_IDLE;
                    end
                    OP_ROTR:
                    begin
                        mem_we     = 1'b1;
                        waddr      = topm1;
                        wdata      = rd_data;
                        top_next   = topm1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        raddr      = slot1;
                        state_next = S_RD2;
                    end
                endcase
            end
            S_RD2:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_SWAP:
                    begin
                        mem_we     = 1'b1;
                        waddr      = top_reg;
                        wdata      = rd_data;
                        state_next = S_SWAP;
                    end
                    OP_ADD, OP_SUB:
                    begin
                        mem_we     = 1'b1;
                        waddr      = slot1;
                        wdata      = (op_reg == OP_ADD) ? rd_data + b_reg : rd_data - b_reg;
                        top_next   = slot1;
                        count_next = count_reg - 1'b1;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (b_reg == '0)
                        begin
                            do_fail     = 1'b1;
                            fail_status = ST_DIVZ;
                        end
                        else
                        begin
                            alu_start  = 1'b1;
                            state_next = S_ALU;
                        end
                    end
                    OP_MUL:
                    begin
                        alu_start  = 1'b1;
                        state_next = S_ALU;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SWAP:
            begin
                mem_we     = 1'b1;
                waddr      = slot1;
                wdata      = b_reg;
                state_next = S_IDLE;
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    mem_we     = 1'b1;
                    waddr      = slot1;
                    wdata      = alu_result;
                    top_next   = slot1;
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK_RD:
            begin
                raddr      = slot_of(top_reg, idx_reg);
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_EMIT;
                if (op_reg == OP_PALL)
                begin
                    res_next = mk_res(KIND_INT, rd_data, idx_next == count_reg);
                    ret_next = (idx_next == count_reg) ? S_IDLE : S_WALK_RD;
                end
                else if (is_strch(rd_data))
                begin
                    res_next = mk_res(KIND_STRCH, rd_data, 1'b0);
                    ret_next = (idx_next == count_reg) ? S_STREND : S_WALK_RD;
                end
                else
                begin
                    res_next = mk_res(KIND_STREND, '0, 1'b1);
                    ret_next = S_IDLE;
                end
            end
            S_STREND:
            begin
                res_next   = mk_res(KIND_STREND, '0, 1'b1);
                ret_next   = S_IDLE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_fail)
        begin
            mem_we          = 1'b0;
            alu_start       = 1'b0;
            res_next        = mk_res(KIND_ERR, '0, 1'b1);
            res_next.status = fail_status;
            ret_next        = S_IDLE;
            state_next      = S_EMIT;
            if (fail_status != ST_HALTED)
            begin
                top_next    = '0;
                count_next  = '0;
                halted_next = 1'b1;
            end
            else
            begin
                top_next   = top_reg;
                count_next = count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[raddr];
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            top_reg    <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            top_reg    <= top_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        b_reg   <= b_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

endmodule

### hdl/stack_machine_interpreter_core_top.sv
// ----------------------------------------------------------------------------
// stack_machine_interpreter_core_top
// Stack machine interpreter: command queue, execution back end, result queue.
//
// Commands enter a four-deep queue and results leave through a four-deep
// queue, so either side may stall without stopping the other. The back end
// runs one command at a time: push, pop, nop and rotate with fewer than two
// entries complete in the idle state; print top, print char and the rotates
// read one stack entry, and swap and the arithmetic commands read two, swap
// writing both back; mul, div and mod then wait on the bit-serial arithmetic
// unit. Each result beat waits in the emit state for room in the result queue;
// print all and print string walk the stack through its registered read port.
// The stack memory is not cleared at reset; entries are only read once written.
// ----------------------------------------------------------------------------
module stack_machine_interpreter_core_top #(
    parameter int DEPTH      = 32,
    parameter int WORD_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic [3:0]          mode,
    input  logic signed [31:0]  push_value,
    input  logic                push,
    output logic                full,
    output logic [2:0]          kind,
    output logic signed [31:0]  out_value,
    output logic [2:0]          status,
    output logic                last,
    output logic                empty,
    input  logic                pop
);
    import smi_pkg::*;

    logic   push_at_bottom_reg;
    cmd_t   cmd;
    logic   cq_empty;
    logic   cmd_pop;
    res_t   res_in;
    res_t   res_out;
    logic   oq_push;
    logic   oq_full;
    stat_t  stat;
    logic   cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == REG_PUSH_AT_BOTTOM[0]);
    assign prdata  = cfg_hit ? {31'b0, push_at_bottom_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_at_bottom_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            push_at_bottom_reg <= pwdata[0];
        end
    end

    smi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode),
        .push_value (push_value),
        .push       (push),
        .full       (full),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd),
        .cmd_empty  (cq_empty)
    );

    smi_back #(.DEPTH(DEPTH), .W(WORD_WIDTH)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .push_at_bottom (push_at_bottom_reg),
        .cmd            (cmd),
        .cmd_empty      (cq_empty),
        .cmd_pop        (cmd_pop),
        .res            (res_in),
        .res_push       (oq_push),
        .res_full       (oq_full),
        .stat           (stat)
    );

    smi_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (oq_push),
        .res_in   (res_in),
        .res_full (oq_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign kind      = res_out.kind;
    assign out_value = res_out.value;
    assign status    = res_out.status;
    assign last      = res_out.last;

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> !oq_full)
        else $error("result beat pushed into full queue");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        stat.halted |=> stat.halted)
        else $error("halt released without reset");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cq_empty)
        else $error("command taken from empty queue");

endmodule

### bench/stack_machine_interpreter_core_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_machine_interpreter_core_top_tb
// Drives commands through the input queue and checks every result beat,
// field by field, against a cycle-free model of the stack machine. A directed
// table covers the extremes and every command. Random phases follow, with
// the sender and receiver idling in turn and push mode changed between them.
// The run closes by forcing one error, then sending commands to the halted
// core.
// ----------------------------------------------------------------------------
module stack_machine_interpreter_core_top_tb;
    import smi_pkg::*;

    localparam int SLOTS     = 32;
    localparam int MAX_CYC   = 500000;
    localparam int DRAIN_CYC = 400;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] value;
        bit          typed;
        kind_t       kind;
        logic [31:0] res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic [3:0]         mode;
    logic signed [31:0] push_value;
    logic               push;
    logic               full;
    logic [2:0]         kind;
    logic signed [31:0] out_value;
    logic [2:0]         status;
    logic               last;
    logic               empty;
    logic               pop;

    // model state
    logic [31:0] words [SLOTS];
    logic [4:0]  top_slot;
    int          depth_used;
    bit          stopped;
    bit          at_bottom;

    res_t        pending_beats [$];
    int          errors;
    int          cycles;
    int          tx_idle;
    int          rx_idle;

    dir_row_t dir_tab [29] = '{
        '{OP_PALL,  32'h0,        0, KIND_INT,  32'h0},
        '{OP_ROTL,  32'h0,        0, KIND_INT,  32'h0},
        '{OP_PUSH,  32'h7fffffff, 0, KIND_INT,  32'h0},
        '{OP_PUSH,  32'h80000000, 0, KIND_INT,  32'h0},
        '{OP_PINT,  32'h0,        1, KIND_INT,  32'h80000000},
        '{OP_ADD,   32'h0,        0, KIND_INT,  32'h0},
        '{OP_PINT,  32'h0,        1, KIND_INT,  32'hffffffff},
        '{OP_PUSH,  32'h80000000, 0, KIND_INT,  32'h0},
        '{OP_PUSH,  32'hffffffff, 0, KIND_INT,  32'h0},
        '{OP_DIV,   32'h0,        0, KIND_INT,  32'h0},
        '{OP_PINT,  32'h0,        1, KIND_INT,  32'h80000000},
        '{OP_PUSH,  32'hffffffff, 0, KIND_INT,  32'h0},
        '{OP_MOD,   32'h0,        0, KIND_INT,  32'h0},
        '{OP_PINT,  32'h0,        1, KIND_INT,  32'h0},
        '{OP_PUSH,  32'd72,       0, KIND_INT,  32'h0},
        '{OP_PCHAR, 32'h0,        1, KIND_CHAR, 32'd72},
        '{OP_PUSH,  32'd105,      0, KIND_INT,  32'h0},
        '{OP_SWAP,  32'h0,        0, KIND_INT,  32'h0},
        '{OP_PSTR,  32'h0,        0, KIND_INT,  32'h0},
        '{OP_MUL,   32'h0,        0, KIND_INT,  32'h0},
        '{OP_SUB,   32'h0,        0, KIND_INT,  32'h0},
        '{OP_ROTL,  32'h0,        0, KIND_INT,  32'h0},
        '{OP_ROTR,  32'h0,        0, KIND_INT,  32'h0},
        '{OP_PALL,  32'h0,        0, KIND_INT,  32'h0},
        '{OP_POP,   32'h0,        0, KIND_INT,  32'h0},
        '{OP_NOP,   32'h0,        0, KIND_INT,  32'h0},
        '{4'd15,    32'h0,        0, KIND_INT,  32'h0},
        '{OP_PUSH,  32'd127,      0, KIND_INT,  32'h0},
        '{OP_PCHAR, 32'h0,        1, KIND_CHAR, 32'd127}
    };

    stack_machine_interpreter_core_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mode       (mode),
        .push_value (push_value),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .out_value  (out_value),
        .status     (status),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [4:0] slot_of(int i);
        return 5'((top_slot + i) % SLOTS);
    endfunction

    function automatic void add_beat(kind_t k, logic [31:0] v, status_t s);
        res_t r;
        r.kind   = k;
        r.value  = v;
        r.status = s;
        r.last   = 1'b0;
        pending_beats.push_back(r);
    endfunction

    function automatic void halt_with(status_t s);
        top_slot   = '0;
        depth_used = 0;
        stopped    = 1'b1;
        add_beat(KIND_ERR, 32'h0, s);
    endfunction

    // advance the model by one command, queue the beats it yields
    function automatic void run_command(logic [3:0] op, logic [31:0] v);
        int          n0;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] ma;
        logic [31:0] mb;
        n0 = pending_beats.size();
        if (stopped)
        begin
            add_beat(KIND_ERR, 32'h0, ST_HALTED);
        end
        else
        begin
            case (op)
                OP_PUSH:
                    if (depth_used >= SLOTS)
                        halt_with(ST_FULL);
                    else
                    begin
                        if (at_bottom)
                            words[slot_of(depth_used)] = v;
                        else
                        begin
                            top_slot        = top_slot - 5'd1;
                            words[top_slot] = v;
                        end
                        depth_used++;
                    end
                OP_PALL:
                    for (int i = 0; i < depth_used; i++)
                        add_beat(KIND_INT, words[slot_of(i)], ST_OK);
                OP_PINT:
                    if (depth_used == 0)
                        halt_with(ST_EMPTY);
                    else
                        add_beat(KIND_INT, words[top_slot], ST_OK);
                OP_POP:
                    if (depth_used == 0)
                        halt_with(ST_EMPTY);
                    else
                    begin
                        top_slot = slot_of(1);
                        depth_used--;
                    end
                OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD:
                    if (depth_used < 2)
                        halt_with(ST_SHORT);
                    else
                    begin
                        b = words[top_slot];
                        a = words[slot_of(1)];
                        if ((op == OP_DIV || op == OP_MOD) && b == 0)
                            halt_with(ST_DIVZ);
                        else if (op == OP_SWAP)
                        begin
                            words[top_slot]   = a;
                            words[slot_of(1)] = b;
                        end
                        else
                        begin
                            ma = a[31] ? -a : a;
                            mb = b[31] ? -b : b;
                            case (op)
                                OP_ADD:  r = a + b;
                                OP_SUB:  r = a - b;
                                OP_MUL:  r = a * b;
                                OP_DIV:  r = (a[31] != b[31]) ? -(ma / mb) : ma / mb;
                                default: r = a[31] ? -(ma % mb) : ma % mb;
                            endcase
                            top_slot        = slot_of(1);
                            depth_used--;
                            words[top_slot] = r;
                        end
                    end
                OP_PCHAR:
                    if (depth_used == 0)
                        halt_with(ST_EMPTY);
                    else if (words[top_slot][31] || words[top_slot] > 127)
                        halt_with(ST_CHAR);
                    else
                        add_beat(KIND_CHAR, words[top_slot], ST_OK);
                OP_PSTR:
                begin
                    for (int i = 0; i < depth_used; i++)
                    begin
                        a = words[slot_of(i)];
                        if (a[31] || a == 0 || a > 127)
                            break;
                        add_beat(KIND_STRCH, a, ST_OK);
                    end
                    add_beat(KIND_STREND, 32'h0, ST_OK);
                end
                OP_ROTL:
                    if (depth_used >= 2)
                    begin
                        a        = words[top_slot];
                        top_slot = slot_of(1);
                        words[slot_of(depth_used - 1)] = a;
                    end
                OP_ROTR:
                    if (depth_used >= 2)
                    begin
                        a               = words[slot_of(depth_used - 1)];
                        top_slot        = top_slot - 5'd1;
                        words[top_slot] = a;
                    end
                default:
                    ;
            endcase
        end
        if (pending_beats.size() > n0)
            pending_beats[pending_beats.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic send_cmd(logic [3:0] op, logic [31:0] v);
        while (tx_idle > 0 && $urandom_range(0, 99) < tx_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        mode       <= op;
        push_value <= v;
        push       <= 1'b1;
        do
            @(posedge clk);
        while (full);
        run_command(op, v);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'($urandom_range(1, 127));
            1:       return 32'($urandom_range(1, 127));
            2:       return 32'h80000000 ^ 32'($urandom_range(0, 1) * 32'hffffffff);
            3:       return 32'($urandom_range(0, 1)) - 32'd1;
            default: return $urandom();
        endcase
    endfunction

    // random command, steered away from the errors that would halt the core
    task automatic send_legal();
        logic [3:0]  op;
        logic [31:0] v;
        v  = pick_word();
        op = ($urandom_range(0, 99) < 35) ? OP_PUSH : 4'($urandom_range(1, 15));
        if (op == OP_PUSH && depth_used >= SLOTS)
            op = OP_POP;
        if ((op == OP_PINT || op == OP_POP || op == OP_PCHAR) && depth_used == 0)
            op = OP_PUSH;
        if (op >= OP_SWAP && op <= OP_MOD && depth_used < 2)
            op = OP_PUSH;
        if ((op == OP_DIV || op == OP_MOD) && words[top_slot] == 0)
            op = OP_ADD;
        if (op == OP_PCHAR && (words[top_slot][31] || words[top_slot] > 127))
            op = OP_PINT;
        send_cmd(op, v);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch("unexpected beat", out_value, 32'h0);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (kind != want.kind)
                    report_mismatch("kind", 32'(kind), 32'(want.kind));
                if (out_value != want.value)
                    report_mismatch("out_value", out_value, want.value);
                if (status != want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (last != want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    always @(negedge clk)
        pop <= (rx_idle == 0) || ($urandom_range(0, 99) >= rx_idle);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("stack_machine_interpreter_core_top_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mode       = OP_NOP;
        push_value = '0;
        push       = 1'b0;
        pop        = 1'b0;
        errors     = 0;
        cycles     = 0;
        tx_idle    = 0;
        rx_idle    = 0;
        top_slot   = '0;
        depth_used = 0;
        stopped    = 1'b0;
        at_bottom  = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(REG_PUSH_AT_BOTTOM, 32'd0);
        at_bottom = 1'b0;
        foreach (dir_tab[i])
        begin
            send_cmd(dir_tab[i].op, dir_tab[i].value);
            if (dir_tab[i].typed)
            begin
                void'(pending_beats.pop_back());
                add_beat(dir_tab[i].kind, dir_tab[i].res, ST_OK);
                pending_beats[pending_beats.size() - 1].last = 1'b1;
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            at_bottom = (ph != 1);
            write_reg(REG_PUSH_AT_BOTTOM, 32'(at_bottom));
            tx_idle = (ph == 0) ? 15 : (ph == 1) ? 88 : 0;
            rx_idle = (ph == 0) ? 88 : (ph == 1) ? 15 : 0;
            repeat (30) send_legal();
        end

        // force one error, then talk to the halted core
        case ($urandom_range(0, 5))
            0:
                while (!stopped)
                    send_cmd(OP_PUSH, $urandom());
            1:
            begin
                while (depth_used > 0)
                    send_cmd(OP_POP, 32'h0);
                send_cmd(OP_PINT, 32'h0);
            end
            2:
            begin
                while (depth_used > 0)
                    send_cmd(OP_POP, 32'h0);
                send_cmd(OP_PCHAR, 32'h0);
            end
            3:
            begin
                while (depth_used > 1)
                    send_cmd(OP_POP, 32'h0);
                send_cmd(4'($urandom_range(OP_SWAP, OP_MOD)), 32'h0);
            end
            4:
            begin
                send_cmd(OP_PUSH, $urandom());
                send_cmd(OP_PUSH, 32'h0);
                send_cmd($urandom_range(0, 1) ? OP_DIV : OP_MOD, 32'h0);
            end
            default:
            begin
                send_cmd(OP_PUSH, $urandom_range(0, 1) ? 32'd128 : 32'hffffff80);
                send_cmd(OP_PCHAR, 32'h0);
            end
        endcase
        repeat (3) send_cmd(4'($urandom_range(0, 15)), $urandom());

        drain();
        if (errors == 0)
            $display("stack_machine_interpreter_core_top_tb OK");
        else
            $display("stack_machine_interpreter_core_top_tb NOT OK");
        $finish;
    end

endmodule
